### sv/spcf_pkg.sv
// ============================================================================
// spcf_pkg
// Types, constants and helpers shared by the servo position command framer.
// ============================================================================
package spcf_pkg;

    localparam int JOINT_COUNT  = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int PIN_MAP_W    = 30;
    localparam int MAPPED_LEGS  = 6;

    // Pulse width arithmetic. The reciprocal of 991 scaled by 1000 and by
    // 2**20 is exact for every clamped angle offset in 0..1800.
    localparam logic signed [11:0] ANGLE_LIMIT = 12'sd900;
    localparam logic [11:0]        PWM_BASE    = 12'd592;
    localparam logic [31:0]        RECIP_MUL   = 32'd1058099;
    localparam int                 RECIP_SHIFT = 20;

    localparam logic [7:0]  POS_HEADER    = 8'h80;
    localparam logic [7:0]  COMMIT_HEADER = 8'hA1;
    localparam logic [7:0]  NONE_HEADER   = 8'h00;
    localparam logic [15:0] FREE_TIME     = 16'd200;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_LEG    = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_FREE   = 2'd3
    } t_cmd;

    // Configuration register indexes, also the joint numbers.
    localparam logic [1:0] CFG_COXA  = 2'd0;
    localparam logic [1:0] CFG_FEMUR = 2'd1;
    localparam logic [1:0] CFG_TIBIA = 2'd2;

    localparam logic [1:0] JNT_COXA  = 2'd0;
    localparam logic [1:0] JNT_FEMUR = 2'd1;
    localparam logic [1:0] JNT_TIBIA = 2'd2;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic        is_free;
        logic [7:0]  header;
        logic [15:0] payload;
        logic        sent;
        logic        last;
    } t_job;

    // Channel number of one leg from a pin map; legs past the sixth read 0.
    function automatic logic [4:0] pin_of(input logic [PIN_MAP_W-1:0] map,
                                          input logic [2:0] leg);
        logic [4:0] ch;
        unique case (leg)
            3'd0:    ch = map[4:0];
            3'd1:    ch = map[9:5];
            3'd2:    ch = map[14:10];
            3'd3:    ch = map[19:15];
            3'd4:    ch = map[24:20];
            3'd5:    ch = map[29:25];
            default: ch = 5'd0;
        endcase
        return ch;
    endfunction

endpackage

### sv/spcf_cmd_if.sv
// ============================================================================
// spcf_cmd_if
// Command channel: one begin, leg update, commit or free per transfer.
// ============================================================================
interface spcf_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [2:0]         leg_index;
    logic signed [10:0] coxa_angle;
    logic signed [10:0] femur_angle;
    logic signed [10:0] tibia_angle;
    logic [15:0]        move_time;

    modport source (output valid, command, leg_index, coxa_angle, femur_angle,
                    tibia_angle, move_time, input ready);
    modport sink   (input valid, command, leg_index, coxa_angle, femur_angle,
                    tibia_angle, move_time, output ready);
endinterface

### sv/spcf_frm_if.sv
// ============================================================================
// spcf_frm_if
// Frame channel: one servo controller command per transfer.
// ============================================================================
interface spcf_frm_if;
    logic        valid;
    logic        ready;
    logic [7:0]  header;
    logic [15:0] payload;
    logic        sent;
    logic        last;

    modport source (output valid, header, payload, sent, last, input ready);
    modport sink   (input valid, header, payload, sent, last, output ready);
endinterface

### sv/spcf_front.sv
// ============================================================================
// spcf_front
// Accepts commands, converts joint angles to pulse widths, compares them with
// the stored widths and queues one job per frame, or one job for a whole free.
// ============================================================================
module spcf_front
    import spcf_pkg::*;
#(
    parameter int LEG_COUNT = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spcf_cmd_if.sink          i_cmd,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [PIN_MAP_W-1:0] i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    localparam int LEG_W = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_EMIT
    } t_state;

    t_state                     r_state;
    logic                       r_changed;
    logic                       r_active;
    logic [PIN_MAP_W-1:0]       r_pin_map [JOINT_COUNT];
    logic [11:0]                r_last_w  [JOINT_COUNT][LEG_COUNT];
    logic [2:0]                 r_leg;
    logic signed [10:0]         r_angle   [JOINT_COUNT];
    logic [31:0]                r_prod    [JOINT_COUNT];
    logic [11:0]                r_width   [JOINT_COUNT];
    logic [JOINT_COUNT-1:0]     r_mask;
    logic [1:0]                 r_joint;

    logic                       w_accept;
    logic                       w_advance;
    logic                       w_last_joint;
    logic [10:0]                w_offset  [JOINT_COUNT];
    logic [11:0]                w_width   [JOINT_COUNT];
    logic [LEG_W-1:0]           w_slot;
    logic signed [11:0]         w_ext;

    assign i_cmd.ready = (r_state == ST_IDLE) && !i_q_full;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_slot      = LEG_W'(r_leg);

    // Clamp to +-90.0 degrees and shift into 0..1800.
    always_comb begin
        for (int j = 0; j < JOINT_COUNT; j++) begin
            w_ext = 12'(r_angle[j]);
            if (w_ext > ANGLE_LIMIT) begin
                w_ext = ANGLE_LIMIT;
            end else if (w_ext < -ANGLE_LIMIT) begin
                w_ext = -ANGLE_LIMIT;
            end
            w_offset[j] = 11'(w_ext + ANGLE_LIMIT);
            w_width[j]  = 12'(r_prod[j] >> RECIP_SHIFT) + PWM_BASE;
        end
    end

    // A position frame is the last one of its update when no later joint
    // has changed.
    always_comb begin
        unique case (r_joint)
            JNT_COXA:  w_last_joint = !r_mask[1] && !r_mask[2];
            JNT_FEMUR: w_last_joint = !r_mask[2];
            default:   w_last_joint = 1'b1;
        endcase
    end

    assign w_advance = !r_mask[r_joint] || !i_q_full;

    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && t_cmd'(i_cmd.command) == CMD_COMMIT) begin
                    o_push = 1'b1;
                    o_job.last = 1'b1;
                    if (r_changed) begin
                        o_job.header  = COMMIT_HEADER;
                        o_job.payload = i_cmd.move_time;
                        o_job.sent    = 1'b1;
                    end else begin
                        o_job.header  = NONE_HEADER;
                    end
                end else if (w_accept && t_cmd'(i_cmd.command) == CMD_FREE
                             && r_active) begin
                    o_push        = 1'b1;
                    o_job.is_free = 1'b1;
                    o_job.sent    = 1'b1;
                    o_job.last    = 1'b1;
                end
            end
            ST_EMIT: begin
                if (r_mask[r_joint] && !i_q_full) begin
                    o_push        = 1'b1;
                    o_job.header  = POS_HEADER
                                  + {3'b000, pin_of(r_pin_map[r_joint], r_leg)};
                    o_job.payload = {4'h0, r_width[r_joint]};
                    o_job.sent    = 1'b1;
                    o_job.last    = w_last_joint;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_changed <= 1'b0;
            r_active  <= 1'b0;
            r_joint   <= JNT_COXA;
            for (int j = 0; j < JOINT_COUNT; j++) begin
                r_pin_map[j] <= '0;
                for (int l = 0; l < LEG_COUNT; l++) begin
                    r_last_w[j][l] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COXA:  r_pin_map[JNT_COXA]  <= i_cfg_data;
                    CFG_FEMUR: r_pin_map[JNT_FEMUR] <= i_cfg_data;
                    CFG_TIBIA: r_pin_map[JNT_TIBIA] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_leg      <= i_cmd.leg_index;
                        r_angle[0] <= i_cmd.coxa_angle;
                        r_angle[1] <= i_cmd.femur_angle;
                        r_angle[2] <= i_cmd.tibia_angle;
                        unique case (t_cmd'(i_cmd.command))
                            CMD_BEGIN: begin
                                r_changed <= 1'b0;
                            end
                            CMD_LEG: begin
                                if ({1'b0, i_cmd.leg_index} < 4'(LEG_COUNT)) begin
                                    r_state <= ST_MUL;
                                end
                            end
                            CMD_COMMIT: begin
                                if (r_changed) begin
                                    r_active <= 1'b1;
                                end
                            end
                            CMD_FREE: begin
                                if (r_active) begin
                                    r_active <= 1'b0;
                                    for (int j = 0; j < JOINT_COUNT; j++) begin
                                        for (int l = 0; l < LEG_COUNT; l++) begin
                                            r_last_w[j][l] <= '0;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    for (int j = 0; j < JOINT_COUNT; j++) begin
                        r_prod[j] <= 32'(w_offset[j]) * RECIP_MUL;
                    end
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    for (int j = 0; j < JOINT_COUNT; j++) begin
                        r_width[j] <= w_width[j];
                        r_mask[j]  <= (r_last_w[j][w_slot] != w_width[j]);
                    end
                    r_joint <= JNT_COXA;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (o_push) begin
                        r_last_w[r_joint][w_slot] <= r_width[r_joint];
                        r_changed <= 1'b1;
                    end
                    if (w_advance) begin
                        if (r_joint == JNT_TIBIA) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_joint <= r_joint + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

### sv/spcf_queue.sv
// ============================================================================
// spcf_queue
// Short job queue between the classifying front and the framing back.
// ============================================================================
module spcf_queue
    import spcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/spcf_back.sv
// ============================================================================
// spcf_back
// Takes jobs from the queue and drives the frame output register; a free job
// expands into one release frame per channel followed by a commit.
// ============================================================================
module spcf_back
    import spcf_pkg::*;
#(
    parameter int CHANNEL_COUNT = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_empty,
    output logic      o_pop,
    spcf_frm_if.source o_frm
);

    localparam int CNT_W = $clog2(CHANNEL_COUNT + 1);

    logic             r_valid;
    logic [7:0]       r_header;
    logic [15:0]      r_payload;
    logic             r_sent;
    logic             r_last;
    logic             r_freeing;
    logic [CNT_W-1:0] r_chan;

    logic             w_load;

    assign w_load = !r_valid || o_frm.ready;
    assign o_pop  = w_load && !r_freeing && !i_empty;

    assign o_frm.valid   = r_valid;
    assign o_frm.header  = r_header;
    assign o_frm.payload = r_payload;
    assign o_frm.sent    = r_sent;
    assign o_frm.last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_freeing <= 1'b0;
            r_chan    <= '0;
        end else if (w_load) begin
            if (r_freeing) begin
                r_valid <= 1'b1;
                r_sent  <= 1'b1;
                if (r_chan == CNT_W'(CHANNEL_COUNT)) begin
                    r_header  <= COMMIT_HEADER;
                    r_payload <= FREE_TIME;
                    r_last    <= 1'b1;
                    r_freeing <= 1'b0;
                end else begin
                    r_header  <= POS_HEADER + {3'b000, 5'(r_chan)};
                    r_payload <= '0;
                    r_last    <= 1'b0;
                    r_chan    <= r_chan + 1'b1;
                end
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                if (i_job.is_free) begin
                    // Channel 0 goes out right away; the rest follow.
                    r_header  <= POS_HEADER;
                    r_payload <= '0;
                    r_sent    <= 1'b1;
                    r_last    <= 1'b0;
                    r_freeing <= 1'b1;
                    r_chan    <= CNT_W'(1);
                end else begin
                    r_header  <= i_job.header;
                    r_payload <= i_job.payload;
                    r_sent    <= i_job.sent;
                    r_last    <= i_job.last;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### sv/servo_position_command_framer.sv
// ============================================================================
// servo_position_command_framer
// Turns leg joint angles into servo position frames, sent only for servos
// whose pulse width changed, plus commit and release-all frames.
// ============================================================================
//  Port        Dir   Handshake        Carries
//  i_cmd       in    valid/ready      command, leg, three angles, move time
//  o_frm       out   valid/ready      header, payload, sent, last
//  i_cfg_*     in    write enable     pin map registers 0..2
//
// Begin, commit and free are taken straight from idle when the job queue has room.
// A leg update holds the front through capture, multiply, compare and one slot
// per joint, longer when the queue is full.
// A free keeps the back busy for CHANNEL_COUNT + 1 output transfers.
// Synchronous reset clears the stored widths, flags, pin maps and queue.
// The four-entry queue lets the front keep accepting while o_frm is stalled.
module servo_position_command_framer
    import spcf_pkg::*;
#(
    parameter int LEG_COUNT     = 6,
    parameter int CHANNEL_COUNT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spcf_cmd_if.sink             i_cmd,
    spcf_frm_if.source           o_frm,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [PIN_MAP_W-1:0] i_cfg_data
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_in_job;
    t_job w_out_job;

    spcf_front #(
        .LEG_COUNT (LEG_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_in_job)
    );

    spcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .i_pop   (w_pop),
        .o_job   (w_out_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    spcf_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_out_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_frm   (o_frm)
    );

endmodule

### sv/spcf_checker.sv
// ============================================================================
// spcf_checker
// Port-level checks on the frame output of the servo command framer.
// ============================================================================
module spcf_checker
    import spcf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_frm_valid,
    input logic        i_frm_ready,
    input logic [7:0]  i_frm_header,
    input logic [15:0] i_frm_payload,
    input logic        i_frm_sent,
    input logic        i_frm_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && !i_frm_ready |=> i_frm_valid && $stable(i_frm_header)
            && $stable(i_frm_payload) && $stable(i_frm_last))
        else $error("frame changed while stalled");

    a_empty_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && !i_frm_sent |-> i_frm_last && i_frm_header == NONE_HEADER
            && i_frm_payload == 16'd0)
        else $error("unsent frame is not a bare final commit");

    a_commit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && i_frm_header == COMMIT_HEADER |-> i_frm_sent && i_frm_last)
        else $error("commit frame not final");

    a_mid_is_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && !i_frm_last |-> i_frm_sent
            && i_frm_header[7:5] == POS_HEADER[7:5])
        else $error("non-final frame is not a position frame");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_frm_valid)
        else $error("frame valid right after reset");

endmodule

bind servo_position_command_framer spcf_checker u_spcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_frm_valid   (o_frm.valid),
    .i_frm_ready   (o_frm.ready),
    .i_frm_header  (o_frm.header),
    .i_frm_payload (o_frm.payload),
    .i_frm_sent    (o_frm.sent),
    .i_frm_last    (o_frm.last)
);

### tb/sv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the servo position command framer. Begin, leg
// update, commit and free commands are sent under random source gaps and
// sink stalls. Each accepted command goes through an in-bench model of the
// width conversion and the change tracking, and every output frame is checked
// field by field against the oldest predicted frame.
// ============================================================================
module tb;
    import spcf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEGS        = 6;
    localparam int CHANNELS    = 32;
    localparam int SERVOS      = LEGS * JOINT_COUNT;
    localparam int ANGLE_CLAMP = 900;
    localparam int WIDTH_SCALE = 1000;
    localparam int WIDTH_DIV   = 991;
    localparam int WIDTH_BASE  = 592;
    localparam int RELEASE_MS  = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 20;
    localparam int PHASE_ITEMS = 115;

    typedef struct {
        t_cmd               command;
        logic [2:0]         leg;
        logic signed [10:0] coxa;
        logic signed [10:0] femur;
        logic signed [10:0] tibia;
        logic [15:0]        move_time;
        bit                 drain;
    } t_order;

    typedef struct {
        logic [7:0]  header;
        logic [15:0] payload;
        logic        sent;
        logic        last;
    } t_frame;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [PIN_MAP_W-1:0] i_cfg_data;

    spcf_cmd_if cmd_if ();
    spcf_frm_if frm_if ();

    servo_position_command_framer #(
        .LEG_COUNT     (LEGS),
        .CHANNEL_COUNT (CHANNELS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if.sink),
        .o_frm       (frm_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Model state.
    logic [11:0]          held_width [SERVOS];
    bit                   width_moved;
    bit                   servos_live;
    logic [PIN_MAP_W-1:0] pin_map [JOINT_COUNT];

    t_order pend_orders [$];
    t_frame due_frames [$];
    int     error_count;
    int     order_count;
    bit     cmd_active;
    bit     cmd_moved;
    bit     frm_moved;

    // Generator memory, so that some updates repeat an earlier angle.
    logic signed [10:0] gen_angle [LEGS][JOINT_COUNT];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [11:0] pulse_width(input logic signed [10:0] angle);
        int a;
        a = angle;
        if (a > ANGLE_CLAMP) a = ANGLE_CLAMP;
        if (a < -ANGLE_CLAMP) a = -ANGLE_CLAMP;
        return 12'((a + ANGLE_CLAMP) * WIDTH_SCALE / WIDTH_DIV + WIDTH_BASE);
    endfunction

    // Works out the frames one accepted command causes and queues them.
    task automatic frame_order(input t_order o);
        t_frame fresh [$];
        t_frame f;
        logic signed [10:0] angles [JOINT_COUNT];
        logic [11:0] w;
        int slot;
        angles[JNT_COXA]  = o.coxa;
        angles[JNT_FEMUR] = o.femur;
        angles[JNT_TIBIA] = o.tibia;
        case (o.command)
            CMD_BEGIN: width_moved = 1'b0;
            CMD_LEG: begin
                if (o.leg < LEGS) begin
                    for (int j = 0; j < JOINT_COUNT; j++) begin
                        w = pulse_width(angles[j]);
                        slot = o.leg * JOINT_COUNT + j;
                        if (held_width[slot] != w) begin
                            f.header  = POS_HEADER + 8'(pin_map[j][5 * o.leg +: 5]);
                            f.payload = 16'(w);
                            f.sent    = 1'b1;
                            f.last    = 1'b0;
                            fresh.push_back(f);
                            held_width[slot] = w;
                            width_moved = 1'b1;
                        end
                    end
                end
            end
            CMD_COMMIT: begin
                if (width_moved) begin
                    f.header  = COMMIT_HEADER;
                    f.payload = o.move_time;
                    f.sent    = 1'b1;
                    servos_live = 1'b1;
                end else begin
                    f.header  = NONE_HEADER;
                    f.payload = 16'd0;
                    f.sent    = 1'b0;
                end
                f.last = 1'b0;
                fresh.push_back(f);
            end
            CMD_FREE: begin
                if (servos_live) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        f.header  = POS_HEADER + 8'(c);
                        f.payload = 16'd0;
                        f.sent    = 1'b1;
                        f.last    = 1'b0;
                        fresh.push_back(f);
                    end
                    f.header  = COMMIT_HEADER;
                    f.payload = 16'(RELEASE_MS);
                    fresh.push_back(f);
                    servos_live = 1'b0;
                    foreach (held_width[i]) held_width[i] = '0;
                end
            end
        endcase
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) due_frames.push_back(fresh[i]);
    endtask

    // Command source: one presented command at a time, a drawn gap before each.
    always @(posedge i_clk) begin : drive_cmd
        int send_gap;
        bit send_calm;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_active = 1'b0;
            cmd_moved  = 1'b0;
            send_gap   = 0;
            send_calm  = 1'b0;
        end else begin
            cmd_moved = cmd_if.valid && cmd_if.ready;
            if (cmd_moved) begin
                frame_order(pend_orders.pop_front());
                cmd_active = 1'b0;
                if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 10);
            end
            if (!cmd_active) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_orders.size() > 0 &&
                             !(pend_orders[0].drain && due_frames.size() > 0)) begin
                    cmd_if.command     <= pend_orders[0].command;
                    cmd_if.leg_index   <= pend_orders[0].leg;
                    cmd_if.coxa_angle  <= pend_orders[0].coxa;
                    cmd_if.femur_angle <= pend_orders[0].femur;
                    cmd_if.tibia_angle <= pend_orders[0].tibia;
                    cmd_if.move_time   <= pend_orders[0].move_time;
                    cmd_active = 1'b1;
                end
            end
            cmd_if.valid <= cmd_active;
        end
    end

    // Frame sink: checks each transfer, then stalls for a drawn number of cycles.
    always @(posedge i_clk) begin : watch_frm
        int take_gap;
        bit take_calm;
        t_frame want;
        if (!i_rst_n) begin
            frm_if.ready <= 1'b0;
            frm_moved = 1'b0;
            take_gap  = 0;
            take_calm = 1'b0;
        end else begin
            frm_moved = frm_if.valid && frm_if.ready;
            if (frm_moved) begin
                if (due_frames.size() == 0) begin
                    report_mismatch("unexpected frame header", frm_if.header, 0);
                end else begin
                    want = due_frames.pop_front();
                    if (frm_if.header !== want.header)
                        report_mismatch("header", frm_if.header, want.header);
                    if (frm_if.payload !== want.payload)
                        report_mismatch("payload", frm_if.payload, want.payload);
                    if (frm_if.sent !== want.sent)
                        report_mismatch("sent", frm_if.sent, want.sent);
                    if (frm_if.last !== want.last)
                        report_mismatch("last", frm_if.last, want.last);
                end
                if ($urandom_range(0, 59) == 0) take_calm = !take_calm;
                take_gap = take_calm ? 0 : $urandom_range(0, 10);
            end
            if (take_gap > 0) begin
                take_gap--;
                frm_if.ready <= 1'b0;
            end else begin
                frm_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run when neither side has moved for too long.
    always @(posedge i_clk) begin : watchdog
        int still_cycles;
        if (!i_rst_n) begin
            still_cycles = 0;
        end else if (cmd_if.valid && cmd_if.ready || frm_if.valid && frm_if.ready) begin
            still_cycles = 0;
        end else begin
            still_cycles++;
            if (still_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d frames outstanding", due_frames.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic queue_order(input t_cmd command, input logic [2:0] leg,
                               input logic signed [10:0] coxa,
                               input logic signed [10:0] femur,
                               input logic signed [10:0] tibia,
                               input logic [15:0] move_time, input bit drain);
        t_order o;
        o.command   = command;
        o.leg       = leg;
        o.coxa      = coxa;
        o.femur     = femur;
        o.tibia     = tibia;
        o.move_time = move_time;
        o.drain     = drain;
        pend_orders.push_back(o);
        if (!(command == CMD_LEG && leg >= LEGS)) order_count++;
    endtask

    task automatic write_pin_maps(input logic [PIN_MAP_W-1:0] coxa_map,
                                  input logic [PIN_MAP_W-1:0] femur_map,
                                  input logic [PIN_MAP_W-1:0] tibia_map);
        logic [PIN_MAP_W-1:0] maps [JOINT_COUNT];
        maps[CFG_COXA]  = coxa_map;
        maps[CFG_FEMUR] = femur_map;
        maps[CFG_TIBIA] = tibia_map;
        for (int r = 0; r < JOINT_COUNT; r++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(r);
            i_cfg_data  <= maps[r];
            pin_map[r]   = maps[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pend_orders.size() > 0 || cmd_active || due_frames.size() > 0)
            @(posedge i_clk);
        // A leg update that changes nothing may still be in the pipeline.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [10:0] pick_angle(input int leg, input int j);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return gen_angle[leg][j];
        if (r < 42) gen_angle[leg][j] = 11'($urandom_range(0, 2047));
        else        gen_angle[leg][j] = 11'(int'($urandom_range(0, 1800)) - ANGLE_CLAMP);
        return gen_angle[leg][j];
    endfunction

    // Mostly well-formed frames (begin, leg updates, commit, sometimes free)
    // with stray commands mixed in.
    task automatic random_orders(input int count);
        int stop_at;
        int legs;
        int leg;
        stop_at = order_count + count;
        while (order_count < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_order(t_cmd'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                            11'($urandom), 11'($urandom), 11'($urandom),
                            16'($urandom), $urandom_range(0, 39) == 0);
            end else begin
                queue_order(CMD_BEGIN, 3'($urandom), 11'($urandom), 11'($urandom),
                            11'($urandom), 16'($urandom), $urandom_range(0, 39) == 0);
                legs = $urandom_range(1, 6);
                for (int k = 0; k < legs; k++) begin
                    leg = $urandom_range(0, LEGS - 1);
                    queue_order(CMD_LEG, 3'(leg), pick_angle(leg, 0), pick_angle(leg, 1),
                                pick_angle(leg, 2), 16'($urandom), 1'b0);
                end
                queue_order(CMD_COMMIT, 3'($urandom), 11'($urandom), 11'($urandom),
                            11'($urandom), 16'($urandom), 1'b0);
                if ($urandom_range(0, 7) == 0)
                    queue_order(CMD_FREE, 3'($urandom), 11'($urandom), 11'($urandom),
                                11'($urandom), 16'($urandom), 1'b0);
            end
        end
    endtask

    initial begin : run
        logic [PIN_MAP_W-1:0] spread [JOINT_COUNT];
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_BEGIN;
        cmd_if.leg_index   = '0;
        cmd_if.coxa_angle  = '0;
        cmd_if.femur_angle = '0;
        cmd_if.tibia_angle = '0;
        cmd_if.move_time   = '0;
        frm_if.ready       = 1'b0;
        error_count        = 0;
        order_count        = 0;
        width_moved        = 1'b0;
        servos_live        = 1'b0;
        foreach (held_width[i]) held_width[i] = '0;
        foreach (pin_map[i]) pin_map[i] = '0;
        foreach (gen_angle[l, j]) gen_angle[l][j] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Distinct channel per servo: joint j of leg l on channel 6*j + l.
        for (int j = 0; j < JOINT_COUNT; j++)
            for (int l = 0; l < LEGS; l++)
                spread[j][5 * l +: 5] = 5'(6 * j + l);
        write_pin_maps(spread[0], spread[1], spread[2]);

        queue_order(CMD_BEGIN, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_FREE, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_COMMIT, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'hFFFF, 1'b0);
        queue_order(CMD_LEG, 3'd0, -11'sd900, 11'sd900, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd0, -11'sd900, 11'sd900, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd5, 11'h400, 11'h3FF, -11'sd901, 16'hFFFF, 1'b0);
        queue_order(CMD_LEG, 3'd5, -11'sd900, 11'sd900, 11'sd901, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd6, 11'sd100, 11'sd200, 11'sd300, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd7, 11'h400, 11'h3FF, 11'sd1, 16'hFFFF, 1'b0);
        queue_order(CMD_COMMIT, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'hFFFF, 1'b0);
        queue_order(CMD_COMMIT, 3'd7, 11'sd0, 11'sd0, 11'sd0, 16'h5A3C, 1'b0);
        queue_order(CMD_BEGIN, 3'd7, 11'h7FF, 11'h7FF, 11'h7FF, 16'hFFFF, 1'b0);
        queue_order(CMD_COMMIT, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h1234, 1'b0);
        queue_order(CMD_LEG, 3'd2, 11'sd1, -11'sd1, 11'sd899, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd3, 11'sd450, -11'sd450, -11'sd899, 16'h0000, 1'b0);
        queue_order(CMD_COMMIT, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_FREE, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_FREE, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h0000, 1'b0);
        // The flag survives a free, so this commit still sends.
        queue_order(CMD_COMMIT, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'h00C8, 1'b0);
        // Stored widths were cleared: the same angles produce frames again.
        queue_order(CMD_LEG, 3'd0, -11'sd900, 11'sd900, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd4, 11'sd0, 11'sd0, 11'sd0, 16'h0000, 1'b0);
        queue_order(CMD_LEG, 3'd1, 11'sd3, 11'sd4, 11'sd5, 16'h0000, 1'b1);
        queue_order(CMD_COMMIT, 3'd0, 11'sd0, 11'sd0, 11'sd0, 16'hA5A5, 1'b0);

        random_orders(PHASE_ITEMS - 23);
        wait_idle();

        write_pin_maps({PIN_MAP_W{1'b1}}, {PIN_MAP_W{1'b1}}, {PIN_MAP_W{1'b1}});
        random_orders(PHASE_ITEMS);
        wait_idle();

        write_pin_maps('0, '0, '0);
        random_orders(PHASE_ITEMS);
        wait_idle();

        write_pin_maps(PIN_MAP_W'($urandom), PIN_MAP_W'($urandom), PIN_MAP_W'($urandom));
        random_orders(PHASE_ITEMS);
        wait_idle();

        if (due_frames.size() > 0)
            report_mismatch("frames never seen", due_frames.size(), 0);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
